### rtl/core/sha_pkg.sv
// Shared types, constants and round functions for the SHA-256 byte stream hasher.
`default_nettype none
package sha_pkg;

    localparam int RoundCount = 64;

    typedef logic [31:0] word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_EMIT
    } hash_state_t;

    localparam logic [7:0] PadByte = 8'h80;
    localparam logic [5:0] LenStart = 6'd56;

    function automatic word_t round_const(input logic [5:0] idx);
        word_t k [64];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
        };
        return k[idx];
    endfunction

    function automatic word_t start_word(input logic [2:0] idx);
        word_t h [8];
        h = '{
            32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
            32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
        };
        return h[idx];
    endfunction

    function automatic word_t ror32(input word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

### rtl/core/sha_stream_if.sv
// Valid/ready channel interfaces for the hasher's input and output beats.
`default_nettype none
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] data_byte;

    modport source (output valid, command, data_byte, input ready);
    modport sink (input valid, command, data_byte, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

### rtl/core/sha_block_ram.sv
// Block buffer memory: 16 words of 32 bits, byte-writable, registered read.
`default_nettype none
module sha_block_ram
    import sha_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       wr_en,
    input  wire logic [3:0] wr_addr,
    input  wire logic [3:0] wr_be,
    input  wire logic [31:0] wr_data,
    input  wire logic [3:0] rd_addr,
    output word_t           rd_data
);

    word_t mem [16];

    // Byte-lane write, big-endian byte 0 in bits 31:24
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            for (int b = 0; b < 4; b++)
            begin
                if (wr_be[b])
                begin
                    mem[wr_addr][8*b +: 8] <= wr_data[8*b +: 8];
                end
            end
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

### rtl/core/sha_round_core.sv
// Compression engine: 16-word schedule window plus one round per cycle while round_en is high.
`default_nettype none
module sha_round_core
    import sha_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  load_en,     // shift a loaded block word into the window
    input  word_t      load_word,
    input  wire logic  init_en,     // copy chain into working vars
    input  word_t      chain [8],
    input  wire logic  round_en,
    input  wire logic [5:0] round_idx,
    output word_t      work [8]
);

    word_t w_reg [16];
    word_t v_reg [8];
    word_t wt, w_new, s0, s1, t1, t2;

    // Schedule word for this round is always window slot 0
    always_comb
    begin
        wt = w_reg[0];
        s0 = ror32(w_reg[1], 7) ^ ror32(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = ror32(w_reg[14], 17) ^ ror32(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = s1 + w_reg[9] + s0 + w_reg[0];
        t1 = v_reg[7] + (ror32(v_reg[4], 6) ^ ror32(v_reg[4], 11) ^ ror32(v_reg[4], 25))
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
           + round_const(round_idx) + wt;
        t2 = (ror32(v_reg[0], 2) ^ ror32(v_reg[0], 13) ^ ror32(v_reg[0], 22))
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    // Window shift on load or round
    always_ff @(posedge clk)
    begin
        if (load_en || round_en)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= load_en ? load_word : w_new;
        end
    end

    // Working variables
    always_ff @(posedge clk)
    begin
        if (init_en)
        begin
            v_reg <= chain;
        end
        else if (round_en)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    assign work = v_reg;

endmodule
`default_nettype wire

### rtl/core/sha256_byte_stream_hasher.sv
// Top level of the SHA-256 byte stream hasher: control sequencer and chaining state.
//
//  channel   dir  payload                               beat
//  in        in   command, data_byte                    one byte or finish
//  out       out  digest_word, word_index, last_word    one digest word
//
// Append: one byte per cycle while idle; the 64th byte starts the load, rounds and fold.
// Finish: padding writes one buffer word a cycle, then one or two block passes,
// then 8 output beats; each digest word is held on the output until taken.
// Reset restores the initial hash values and clears counts; buffer contents persist.
// The block runs one item at a time; input ready is low while a block or digest runs.
`default_nettype none
module sha256_byte_stream_hasher
    import sha_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    sha_in_if.sink     in_ch,
    sha_out_if.source  out_ch
);

    hash_state_t state_reg, state_next;
    logic [5:0]  count_reg, count_next;
    logic [63:0] bits_reg, bits_next;
    word_t       chain_reg [8];
    logic [6:0]  step_reg, step_next;
    logic        final_reg, final_next;   // block pass belongs to a finish
    logic        extra_reg, extra_next;   // a further pad block follows
    logic [3:0]  pad_reg, pad_next;       // buffer word being padded
    logic [2:0]  emit_reg, emit_next;

    logic        wr_en;
    logic [3:0]  wr_addr, wr_be, rd_addr;
    word_t       wr_data, rd_data;
    logic        load_en, init_en, round_en, fold_en;
    word_t       work [8];

    sha_block_ram u_ram (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_be(wr_be),
        .wr_data(wr_data), .rd_addr(rd_addr), .rd_data(rd_data)
    );

    sha_round_core u_core (
        .clk(clk), .load_en(load_en), .load_word(rd_data), .init_en(init_en),
        .chain(chain_reg), .round_en(round_en), .round_idx(step_reg[5:0]),
        .work(work)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        bits_next  = bits_reg;
        step_next  = step_reg;
        final_next = final_reg;
        extra_next = extra_reg;
        pad_next   = pad_reg;
        emit_next  = emit_reg;
        in_ch.ready = 1'b0;
        wr_en   = 1'b0;
        wr_addr = count_reg[5:2];
        wr_be   = 4'b0;
        wr_data = '0;
        rd_addr = step_reg[3:0];
        load_en = 1'b0;
        init_en = 1'b0;
        round_en = 1'b0;
        fold_en = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_ch.valid)
                begin
                    if (!in_ch.command)
                    begin
                        wr_en = 1'b1;
                        wr_be = 4'b1000 >> count_reg[1:0];
                        wr_data = {4{in_ch.data_byte}};
                        bits_next = bits_reg + 64'd8;
                        count_next = count_reg + 6'd1;
                        if (count_reg == 6'd63)
                        begin
                            state_next = ST_LOAD;
                            step_next = '0;
                            final_next = 1'b0;
                        end
                    end
                    else
                    begin
                        // pad byte into current slot, zero rest of that word
                        wr_en = 1'b1;
                        wr_be = 4'b1111 >> count_reg[1:0];
                        wr_data = {4{PadByte}} & ~(32'hffffffff >> (8 * count_reg[1:0])
                                  >> 8);
                        pad_next = count_reg[5:2] + 4'd1;
                        extra_next = (count_reg >= LenStart);
                        final_next = 1'b1;
                        if (count_reg[5:2] == 4'd15)
                        begin
                            // pad byte landed in the last word: block is complete
                            state_next = ST_LOAD;
                            step_next = '0;
                        end
                        else
                        begin
                            state_next = ST_PAD;
                        end
                    end
                end
            end
            ST_PAD:
            begin
                // one buffer word a cycle: zeros, then the length words unless another pad block follows
                wr_en = 1'b1;
                wr_addr = pad_reg;
                wr_be = 4'b1111;
                if (!extra_reg && pad_reg == 4'd14)
                    wr_data = bits_reg[63:32];
                else if (!extra_reg && pad_reg == 4'd15)
                    wr_data = bits_reg[31:0];
                else
                    wr_data = '0;
                pad_next = pad_reg + 4'd1;
                if (pad_reg == 4'd15)
                begin
                    state_next = ST_LOAD;
                    step_next = '0;
                end
            end
            ST_LOAD:
            begin
                // step 0 issues read, steps 1..16 shift words in
                if (step_reg != 7'd0)
                    load_en = 1'b1;
                rd_addr = step_reg[3:0];
                step_next = step_reg + 7'd1;
                if (step_reg == 7'd16)
                begin
                    init_en = 1'b1;
                    state_next = ST_ROUND;
                    step_next = '0;
                end
            end
            ST_ROUND:
            begin
                round_en = 1'b1;
                step_next = step_reg + 7'd1;
                if (step_reg == 7'd63)
                    state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                fold_en = 1'b1;
                if (!final_reg)
                    state_next = ST_IDLE;
                else if (extra_reg)
                begin
                    // second block: all zeros then length
                    extra_next = 1'b0;
                    pad_next = 4'd0;
                    state_next = ST_PAD;
                end
                else
                begin
                    emit_next = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_ch.ready)
                begin
                    emit_next = emit_reg + 3'd1;
                    if (emit_reg == 3'd7)
                    begin
                        state_next = ST_IDLE;
                        count_next = '0;
                        bits_next = '0;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign out_ch.valid = (state_reg == ST_EMIT);
    assign out_ch.digest_word = chain_reg[emit_reg];
    assign out_ch.word_index = emit_reg;
    assign out_ch.last_word = (emit_reg == 3'd7);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            bits_reg  <= '0;
            step_reg  <= '0;
            final_reg <= 1'b0;
            extra_reg <= 1'b0;
            pad_reg   <= '0;
            emit_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            bits_reg  <= bits_next;
            step_reg  <= step_next;
            final_reg <= final_next;
            extra_reg <= extra_next;
            pad_reg   <= pad_next;
            emit_reg  <= emit_next;
        end
    end

    // Chaining words: fold after a block, restart after the last digest beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                chain_reg[i] <= start_word(3'(i));
        end
        else if (fold_en)
        begin
            for (int i = 0; i < 8; i++)
                chain_reg[i] <= chain_reg[i] + work[i];
        end
        else if (state_reg == ST_EMIT && out_ch.ready && emit_reg == 3'd7)
        begin
            for (int i = 0; i < 8; i++)
                chain_reg[i] <= start_word(3'(i));
        end
    end

endmodule
`default_nettype wire
